// ===== rtl/tcw_pkg.sv =====
// shared types and codes of the text console writer
package tcw_pkg;

  typedef enum logic [1:0] {
    ACT_LOCATE = 2'd0,
    ACT_PUT    = 2'd1,
    ACT_EOL    = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] char_code;
    logic [7:0] loc_col;
    logic [7:0] loc_row;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic       scrolled;
    logic       dropped;
  } res_t;

endpackage

// ===== rtl/tcw_fifo.sv =====
// small first-in first-out queue used between the console stages
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rd_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_ok) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/tcw_front.sv =====
// input stage: accepts items, decodes the action and clamps the locate position
module tcw_front #(
  parameter int COLUMNS  = 80,
  parameter int LAST_ROW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic          hold_i,
  input  logic [1:0]    action_i,
  input  logic [7:0]    col_i,
  input  logic [7:0]    row_i,
  input  logic [7:0]    char_code_i,
  output logic          cmd_valid_o,
  output tcw_pkg::cmd_t cmd_o,
  input  logic          cmd_full_i
);

  import tcw_pkg::*;

  localparam logic [7:0] MAX_COL = 8'(COLUMNS - 1);
  localparam logic [7:0] MAX_ROW = 8'(LAST_ROW);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  assign full_o      = hold_i || (valid_q && cmd_full_i);
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    cmd_d           = cmd_q;
    valid_d         = valid_q;
    if (valid_q && !cmd_full_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d           = 1'b1;
      cmd_d.action      = action_e'(action_i);
      cmd_d.col         = col_i;
      cmd_d.row         = row_i;
      cmd_d.char_code   = char_code_i;
      cmd_d.loc_col     = (col_i > MAX_COL) ? MAX_COL : col_i;
      cmd_d.loc_row     = (row_i > MAX_ROW) ? MAX_ROW : row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ===== rtl/tcw_back.sv =====
// execution stage: cell store, cursor, write pointer, scroll and clear sweeps
module tcw_back #(
  parameter int COLUMNS    = 80,
  parameter int LAST_ROW   = 24,
  parameter int STORE_ROWS = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output tcw_pkg::res_t res_o,
  output logic          clearing_o
);

  import tcw_pkg::*;

  localparam int CELLS    = COLUMNS * STORE_ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int TOP_PTR  = LAST_ROW * COLUMNS + COLUMNS - 1;
  localparam int PTR_MAX  = (TOP_PTR > CELLS) ? TOP_PTR : CELLS;
  localparam int PW       = $clog2(PTR_MAX + 1);
  localparam int RW       = $clog2(255 * COLUMNS + 256);
  localparam int SCR_A    = COLUMNS * LAST_ROW;
  localparam int SCR_B    = CELLS - COLUMNS;
  localparam int SCROLL_N = (SCR_A < SCR_B) ? SCR_A : SCR_B;
  localparam int SW       = $clog2(SCROLL_N + 1);

  localparam logic [PW-1:0] COL_P = PW'(COLUMNS);
  localparam logic [RW-1:0] COL_R = RW'(COLUMNS);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_READ   = 4'b0100,
    ST_SCROLL = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [7:0]    col_q, col_d, row_q, row_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [SW-1:0] scnt_q, scnt_d;
  logic          rok_q, rok_d;

  logic [7:0]    mem [CELLS];
  logic [7:0]    rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  logic [PW-1:0] loc_ptr, eol_ptr;
  logic [RW-1:0] rd_idx;
  logic [8:0]    eol_next;
  logic          eol_over;
  logic [7:0]    eol_row;

  assign clearing_o = (state_q == ST_CLEAR);

  assign loc_ptr  = PW'(cmd_i.loc_row) * COL_P + PW'(cmd_i.loc_col);
  assign rd_idx   = RW'(cmd_i.row) * COL_R + RW'(cmd_i.col);
  assign eol_next = {1'b0, row_q} + 9'd1;
  assign eol_over = eol_next > 9'(LAST_ROW);
  assign eol_row  = eol_over ? 8'(LAST_ROW) : eol_next[7:0];
  assign eol_ptr  = PW'(eol_row) * COL_P;

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    ptr_d      = ptr_q;
    clr_d      = clr_q;
    scnt_d     = scnt_q;
    rok_d      = rok_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o            = '0;
    res_o.cursor_col = col_q;
    res_o.cursor_row = row_q;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.action)
            ACT_LOCATE: begin
              col_d            = cmd_i.col;
              row_d            = cmd_i.row;
              ptr_d            = loc_ptr;
              res_push_o       = 1'b1;
              res_o.cursor_col = cmd_i.col;
              res_o.cursor_row = cmd_i.row;
            end
            ACT_PUT: begin
              res_push_o = 1'b1;
              if (cmd_i.char_code != 8'd0) begin
                if (ptr_q < PW'(CELLS)) begin
                  we    = 1'b1;
                  waddr = ptr_q[AW-1:0];
                  wdata = cmd_i.char_code;
                  ptr_d = ptr_q + PW'(1);
                end else begin
                  res_o.dropped = 1'b1;
                end
              end
            end
            ACT_EOL: begin
              col_d = 8'd0;
              row_d = eol_row;
              ptr_d = eol_ptr;
              if (eol_over) begin
                scnt_d  = '0;
                state_d = ST_SCROLL;
              end else begin
                res_push_o       = 1'b1;
                res_o.cursor_col = 8'd0;
                res_o.cursor_row = eol_row;
              end
            end
            ACT_READ: begin
              raddr   = rd_idx[AW-1:0];
              rok_d   = rd_idx < RW'(CELLS);
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_push_o      = 1'b1;
        res_o.read_char = rok_q ? rdata_q : 8'd0;
        state_d         = ST_IDLE;
      end
      ST_SCROLL: begin
        if (scnt_q != SW'(SCROLL_N)) begin
          raddr  = AW'(scnt_q) + AW'(COLUMNS);
          scnt_d = scnt_q + SW'(1);
        end
        if (scnt_q != '0) begin
          we    = 1'b1;
          waddr = AW'(scnt_q - SW'(1));
          wdata = rdata_q;
        end
        if (scnt_q == SW'(SCROLL_N)) begin
          res_push_o     = 1'b1;
          res_o.scrolled = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      col_q   <= '0;
      row_q   <= '0;
      ptr_q   <= '0;
      clr_q   <= '0;
      scnt_q  <= '0;
      rok_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      ptr_q   <= ptr_d;
      clr_q   <= clr_d;
      scnt_q  <= scnt_d;
      rok_q   <= rok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule

// ===== rtl/text_console_writer.sv =====
// top level of the text console writer
//
// Input channel: an item (action_i, col_i, row_i, char_code_i) is taken at a
// rising edge with push high and full low. Result channel: while empty is
// low the oldest result is on the result ports; pop takes it.
// One result per item, in item order.
// Path: a result reaches the result ports through the front register, the
// command queue and the result queue; a read also waits in the read state on
// the registered read port of the cell store.
// Throughput: one item per cycle for locate, put and end of line while the
// result queue has room; after a read the back stage first passes its read state.
// An end of line that scrolls occupies the back stage while it copies
// min(COLUMNS*LAST_ROW, COLUMNS*(STORE_ROWS-1)) cells up one row, one cell
// copied per cycle; items keep queuing until the queue fills.
// Reset: cursor and write pointer return to zero and a sweep clears all
// COLUMNS*STORE_ROWS cells of the cell store, with full held high.
// Receiver stall: a two-deep result queue fills, the back stage halts, the
// command queue and front register fill, and full rises.
module text_console_writer #(
  parameter int COLUMNS    = 80,
  parameter int LAST_ROW   = 24,
  parameter int STORE_ROWS = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] action_i,
  input  logic [7:0] col_i,
  input  logic [7:0] row_i,
  input  logic [7:0] char_code_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_char_o,
  output logic [7:0] cursor_col_o,
  output logic [7:0] cursor_row_o,
  output logic       scrolled_o,
  output logic       dropped_o
);

  import tcw_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t             front_cmd, back_cmd;
  logic             front_valid, cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0] cmd_rdata;
  res_t             back_res, out_res;
  logic             res_push, res_full, clearing;
  logic [RES_W-1:0] res_rdata;

  tcw_front #(
    .COLUMNS  (COLUMNS),
    .LAST_ROW (LAST_ROW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .hold_i      (clearing),
    .action_i    (action_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .char_code_i (char_code_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_full_i  (cmd_full)
  );

  tcw_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign back_cmd = cmd_t'(cmd_rdata);

  tcw_back #(
    .COLUMNS    (COLUMNS),
    .LAST_ROW   (LAST_ROW),
    .STORE_ROWS (STORE_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res),
    .clearing_o  (clearing)
  );

  tcw_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign out_res      = res_t'(res_rdata);
  assign read_char_o  = out_res.read_char;
  assign cursor_col_o = out_res.cursor_col;
  assign cursor_row_o = out_res.cursor_row;
  assign scrolled_o   = out_res.scrolled;
  assign dropped_o    = out_res.dropped;

endmodule

// ===== rtl/tcw_checker.sv =====
// port-level checks on the text console writer, bound to the top level
module tcw_checker #(
  parameter int LAST_ROW = 24
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] read_char_o,
  input logic [7:0] cursor_col_o,
  input logic [7:0] cursor_row_o,
  input logic       scrolled_o,
  input logic       dropped_o
);

  logic [3:0] pend_q, pend_d;
  logic       in_beat, out_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;

  always_comb begin
    pend_d = pend_q;
    if (in_beat && !out_beat) begin
      pend_d = pend_q + 4'd1;
    end else if (out_beat && !in_beat) begin
      pend_d = pend_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_no_result_without_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 4'd0) |-> empty)
    else $error("result shown with no item outstanding");

  a_scroll_parks_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && scrolled_o) |-> (cursor_col_o == 8'd0 && cursor_row_o == 8'(LAST_ROW)))
    else $error("scroll result with cursor off the last row start");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(scrolled_o && dropped_o))
    else $error("scroll and drop flagged together");

  a_flag_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (scrolled_o || dropped_o)) |-> (read_char_o == 8'd0))
    else $error("read byte set on a non-read result");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(read_char_o) && $stable(cursor_col_o)
                         && $stable(cursor_row_o) && $stable(scrolled_o)
                         && $stable(dropped_o)))
    else $error("waiting result changed before pop");

endmodule

bind text_console_writer tcw_checker #(
  .LAST_ROW (LAST_ROW)
) u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .read_char_o  (read_char_o),
  .cursor_col_o (cursor_col_o),
  .cursor_row_o (cursor_row_o),
  .scrolled_o   (scrolled_o),
  .dropped_o    (dropped_o)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench for the text console writer: directed and random beats checked against a behavioral model

module testbench;
  import tcw_pkg::*;

  localparam int COLUMNS       = 80;
  localparam int LAST_ROW      = 24;
  localparam int STORE_ROWS    = 26;
  localparam int CELLS         = COLUMNS * STORE_ROWS;
  localparam int RANDOM_ITEMS  = 940;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 16;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       pop         = 1'b0;
  logic [1:0] action_i    = ACT_LOCATE;
  logic [7:0] col_i       = 8'h00;
  logic [7:0] row_i       = 8'h00;
  logic [7:0] char_code_i = 8'h00;
  logic       full;
  logic       empty;
  logic [7:0] read_char_o;
  logic [7:0] cursor_col_o;
  logic [7:0] cursor_row_o;
  logic       scrolled_o;
  logic       dropped_o;

  logic [7:0]  screen_mem [CELLS];
  logic [7:0]  cur_col;
  logic [7:0]  cur_row;
  int unsigned wr_ptr;
  res_t        pending [$];

  int errors       = 0;
  int items_sent   = 0;
  int reads_sent   = 0;
  int scrolls_seen = 0;
  int drops_seen   = 0;
  int stall_cycles = 0;
  bit quiet        = 1'b0;

  text_console_writer #(
    .COLUMNS   (COLUMNS),
    .LAST_ROW  (LAST_ROW),
    .STORE_ROWS(STORE_ROWS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .char_code_i (char_code_i),
    .empty       (empty),
    .pop         (pop),
    .read_char_o (read_char_o),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .scrolled_o  (scrolled_o),
    .dropped_o   (dropped_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void aim_pointer();
    int unsigned c;
    int unsigned r;
    c = (cur_col > COLUMNS - 1) ? COLUMNS - 1 : cur_col;
    r = (cur_row > LAST_ROW) ? LAST_ROW : cur_row;
    wr_ptr = r * COLUMNS + c;
  endfunction

  function automatic res_t console_step(action_e act, logic [7:0] col, logic [7:0] row,
                                        logic [7:0] ch);
    res_t        r;
    int unsigned next_row;
    int unsigned idx;
    r = '0;
    case (act)
      ACT_LOCATE: begin
        cur_col = col;
        cur_row = row;
        aim_pointer();
      end
      ACT_PUT: begin
        if (ch != 8'h00) begin
          if (wr_ptr < CELLS) begin
            screen_mem[wr_ptr] = ch;
            wr_ptr++;
          end else begin
            r.dropped = 1'b1;
          end
        end
      end
      ACT_EOL: begin
        next_row = cur_row + 1;
        cur_col = 8'h00;
        if (next_row > LAST_ROW) begin
          next_row = LAST_ROW;
          for (int n = 0; n < COLUMNS * LAST_ROW; n++) begin
            if (n + COLUMNS < CELLS) screen_mem[n] = screen_mem[n + COLUMNS];
          end
          r.scrolled = 1'b1;
        end
        cur_row = next_row[7:0];
        aim_pointer();
      end
      default: begin
        idx = row * COLUMNS + col;
        if (idx < CELLS) r.read_char = screen_mem[idx];
      end
    endcase
    r.cursor_col = cur_col;
    r.cursor_row = cur_row;
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_char();
    return ($urandom_range(99) < 3) ? 8'h00 : 8'($urandom_range(255, 1));
  endfunction

  function automatic logic [7:0] pick_col();
    return ($urandom_range(99) < 85) ? 8'($urandom_range(COLUMNS - 1)) : rand_byte();
  endfunction

  function automatic logic [7:0] pick_row();
    return ($urandom_range(99) < 85) ? 8'($urandom_range(STORE_ROWS - 1)) : rand_byte();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_beat(action_e act, logic [7:0] col, logic [7:0] row, logic [7:0] ch);
    res_t r;
    while (!quiet && $urandom_range(99) < 18) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    action_i    <= act;
    col_i       <= col;
    row_i       <= row;
    char_code_i <= ch;
    do @(posedge clk_i); while (full);
    r = console_step(act, col, row, ch);
    pending.push_back(r);
    items_sent++;
    if (act == ACT_READ) reads_sent++;
    if (r.scrolled) scrolls_seen++;
    if (r.dropped) drops_seen++;
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_run(int n);
    repeat (n) send_beat(ACT_PUT, rand_byte(), rand_byte(), rand_char());
  endtask

  // write until the pointer leaves the store, then one to three more puts that get dropped unless the character is zero
  task automatic fill_past_end();
    while (wr_ptr < CELLS) send_beat(ACT_PUT, rand_byte(), rand_byte(), 8'($urandom_range(255, 1)));
    put_run($urandom_range(3, 1));
  endtask

  task automatic check_result();
    res_t want;
    if (pending.size() == 0) begin
      report_mismatch("beat with nothing expected", read_char_o, 0);
      return;
    end
    want = pending.pop_front();
    if (read_char_o !== want.read_char) report_mismatch("read_char", read_char_o, want.read_char);
    if (cursor_col_o !== want.cursor_col)
      report_mismatch("cursor_col", cursor_col_o, want.cursor_col);
    if (cursor_row_o !== want.cursor_row)
      report_mismatch("cursor_row", cursor_row_o, want.cursor_row);
    if (scrolled_o !== want.scrolled) report_mismatch("scrolled", scrolled_o, want.scrolled);
    if (dropped_o !== want.dropped) report_mismatch("dropped", dropped_o, want.dropped);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_result();
    pop <= quiet || ($urandom_range(99) >= 18);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_cleared_store();
    send_beat(ACT_READ, 8'd0, 8'd0, 8'hff);
    send_beat(ACT_READ, 8'd79, 8'd25, 8'h01);
    send_beat(ACT_READ, 8'd0, 8'd26, 8'h00);
    send_beat(ACT_READ, 8'd255, 8'd255, 8'h80);
  endtask

  task automatic test_locate_and_put();
    send_beat(ACT_LOCATE, 8'd255, 8'd255, 8'h00);
    send_beat(ACT_PUT, 8'h00, 8'h00, 8'h41);
    send_beat(ACT_READ, 8'd79, 8'd24, 8'h00);
    send_beat(ACT_LOCATE, 8'd0, 8'd0, 8'hff);
    send_beat(ACT_PUT, 8'hff, 8'hff, 8'h00);
    send_beat(ACT_PUT, 8'h00, 8'h00, 8'hff);
    send_beat(ACT_PUT, 8'h00, 8'h00, 8'h01);
    send_beat(ACT_READ, 8'd0, 8'd0, 8'h00);
    send_beat(ACT_READ, 8'd1, 8'd0, 8'h00);
  endtask

  task automatic test_end_of_line();
    send_beat(ACT_LOCATE, 8'd5, 8'd22, 8'h00);
    send_beat(ACT_PUT, 8'h00, 8'h00, 8'h5a);
    send_beat(ACT_EOL, 8'hff, 8'hff, 8'hff);
    send_beat(ACT_EOL, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_EOL, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_LOCATE, 8'd255, 8'd255, 8'h00);
    send_beat(ACT_EOL, 8'h00, 8'h00, 8'h00);
    send_beat(ACT_READ, 8'd79, 8'd22, 8'h00);
    send_beat(ACT_READ, 8'd5, 8'd20, 8'h00);
  endtask

  task automatic test_store_overflow();
    send_beat(ACT_LOCATE, 8'd79, 8'd24, 8'h00);
    fill_past_end();
    send_beat(ACT_READ, 8'd79, 8'd25, 8'h00);
    send_beat(ACT_READ, 8'd0, 8'd25, 8'h00);
  endtask

  task automatic test_random_traffic();
    int base;
    int kind;
    int r;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      quiet = (items_sent - base >= 400) && (items_sent - base < 600);
      kind = $urandom_range(99);
      if (kind < 40) begin
        send_beat(ACT_LOCATE, pick_col(), pick_row(), rand_byte());
        put_run($urandom_range(20, 1));
        if ($urandom_range(1)) send_beat(ACT_EOL, rand_byte(), rand_byte(), rand_byte());
      end else if (kind < 55) begin
        repeat ($urandom_range(8, 1)) send_beat(ACT_READ, pick_col(), pick_row(), rand_byte());
      end else if (kind < 63) begin
        send_beat(ACT_EOL, rand_byte(), rand_byte(), rand_byte());
      end else if (kind < 75) begin
        send_beat(action_e'($urandom_range(3)), rand_byte(), rand_byte(), rand_byte());
      end else if (kind < 98) begin
        r = $urandom_range(STORE_ROWS - 1);
        send_beat(ACT_LOCATE, pick_col(), 8'(r), rand_byte());
        repeat ($urandom_range(10, 1))
          send_beat(ACT_READ, 8'($urandom_range(COLUMNS - 1)), 8'(r), rand_byte());
      end else begin
        send_beat(ACT_LOCATE, 8'($urandom_range(255, 60)), 8'($urandom_range(255, 24)),
                  rand_byte());
        fill_past_end();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    foreach (screen_mem[i]) screen_mem[i] = 8'h00;
    cur_col = 8'h00;
    cur_row = 8'h00;
    wr_ptr  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_cleared_store();
    wait_results_drained();
    test_locate_and_put();
    test_end_of_line();
    wait_results_drained();
    test_store_overflow();
    test_random_traffic();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d beats: %0d reads, %0d scrolls, %0d dropped writes", items_sent,
             reads_sent, scrolls_seen, drops_seen);
    $display("random idling on both sides, one idle-free stretch, drain pauses between tests");
    if (errors == 0 && pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
